// ----- hdl/binary_min_heap_macros.svh -----
// assertion macros for the binary min-heap
// no dependencies; taken in by binary_min_heap, which checks its own logic
`ifndef BINARY_MIN_HEAP_MACROS_SVH
`define BINARY_MIN_HEAP_MACROS_SVH

`ifndef SYNTHESIS

// checked property, held off while reset is asserted
`define BMH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds across reset
`define BMH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BMH_ASSERT(label, clk, rst_n, prop, msg)

`define BMH_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- hdl/bmh_pkg.sv -----
// shared types and constants of the binary min-heap
// no dependencies
package bmh_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 6;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef logic signed [KEY_W-1:0] t_key;

    // what one cell shows its neighbours
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             valid;
        logic             gt;     // slot empty or holds a key above the request key
        logic             seen;   // a match lies at or before this cell
    } t_link;

    // broadcast control to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             scan;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

// ----- hdl/bmh_stream_if.sv -----
// request and result channels of the binary min-heap
// depends on bmh_pkg
interface bmh_req_if;
    import bmh_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [KEY_W-1:0] key_value;

    modport source (output valid, output req_type, output key_value, input ready);
    modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface bmh_res_if;
    import bmh_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  entry_total;
    logic                min_valid;
    logic [KEY_W-1:0]    min_key;

    modport source (output valid, output status, output entry_total, output min_valid,
                    output min_key, input ready);
    modport sink   (input valid, input status, input entry_total, input min_valid,
                    input min_key, output ready);
endinterface

// ----- hdl/binary_min_heap.sv -----
// top level of the binary min-heap priority queue
// depends on bmh_pkg, bmh_stream_if, bmh_cell and binary_min_heap_macros.svh
//
// priority queue of signed 32-bit keys, up to CAPACITY entries
// i_req carries one word per request: req_type (insert or remove) and key_value
// o_res carries one word per request: status, entry_total, min_valid, min_key
// both channels move a word at a clock edge where valid and ready are high
// keys sit in a chain of cells kept in ascending order, smallest in cell 0
// an insert lands in S_APPLY: every larger key moves one cell up
// a remove first ripples a match flag along the chain, one cell a cycle,
// through the S_SCAN state, then closes the gap in S_APPLY
// an insert goes from request word through S_APPLY and S_EMIT to the result;
// a remove runs the S_SCAN match ripple before S_APPLY, so it takes longer
// one request is worked at a time; the next is taken once the result sits
// in the output register, so a new word goes in while the last result waits
// a stalled receiver holds the result word and blocks only the next emit
// reset (synchronous, active low) empties the queue at once; no sweep is run
// status codes: ok, full on insert, empty on remove, key not found
`include "binary_min_heap_macros.svh"

module binary_min_heap #(
    parameter int CAPACITY = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bmh_req_if.sink   i_req,
    bmh_res_if.source o_res
);
    import bmh_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic                r_type;
    logic [KEY_W-1:0]    r_key;
    logic [SW-1:0]       r_scan;
    logic [SW-1:0]       n_scan;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [TOTAL_W-1:0]  r_out_total;
    logic                r_out_min_valid;
    logic [KEY_W-1:0]    r_out_min_key;

    logic       w_accept;
    logic       w_out_free;
    logic       w_emit;
    logic       w_full;
    logic       w_found;
    t_cell_ctl  w_ctl;
    t_link      w_link [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    t_link      w_tie;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_emit      = (r_state == S_EMIT) && w_out_free;
    assign w_full      = (r_count == CW'(CAPACITY));
    // at the end of the scan the last cell knows whether any cell matched
    assign w_found     = w_link[CAPACITY-1].seen;

    assign w_ctl.key  = r_key;
    assign w_ctl.scan = (r_state == S_SCAN);
    assign w_ctl.ins  = (r_state == S_APPLY) && (r_type == REQ_INSERT) && !w_full;
    assign w_ctl.rem  = (r_state == S_APPLY) && (r_type == REQ_REMOVE)
                        && (r_count != '0) && w_found;

    // ends of the chain: nothing below cell 0, an empty slot above the last
    assign w_tie.key   = '0;
    assign w_tie.valid = 1'b0;
    assign w_tie.gt    = 1'b0;
    assign w_tie.seen  = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_link w_prev;
            t_link w_next;
            if (gi == 0) begin : g_first
                assign w_prev = w_tie;
            end else begin : g_mid_lo
                assign w_prev = w_link[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_next = w_tie;
            end else begin : g_mid_hi
                assign w_next = w_link[gi+1];
            end
            bmh_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_link  (w_link[gi])
            );
            assign w_valid[gi] = w_link[gi].valid;
        end
    endgenerate

    // request sequencing
    always_comb begin
        n_state  = r_state;
        n_scan   = r_scan;
        n_count  = r_count;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_scan = '0;
                    if (i_req.req_type == REQ_INSERT) begin
                        n_state = S_APPLY;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_scan = r_scan + SW'(1);
                if (r_scan == SW'(CAPACITY - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_EMIT;
                if (r_type == REQ_INSERT) begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_OK;
                        n_count  = r_count + CW'(1);
                    end
                end else if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count - CW'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_scan   <= n_scan;
        r_status <= n_status;
        if (w_accept) begin
            r_type <= i_req.req_type;
            r_key  <= i_req.key_value;
        end
        // result word taken from the chain once the operation has settled
        if (w_emit) begin
            r_out_status    <= r_status;
            r_out_total     <= TOTAL_W'(r_count);
            r_out_min_valid <= w_link[0].valid;
            r_out_min_key   <= w_link[0].valid ? w_link[0].key : '0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.entry_total = r_out_total;
    assign o_res.min_valid   = r_out_min_valid;
    assign o_res.min_key     = r_out_min_key;

    // occupied cells always number exactly the entry count
    `BMH_ASSERT(a_count_matches_cells, i_clk, i_rst_n, ($countones(w_valid) == int'(r_count)), "cell occupancy disagrees with entry count")
    // count never passes capacity
    `BMH_ASSERT(a_count_bound, i_clk, i_rst_n, (r_count <= CW'(CAPACITY)), "entry count above capacity")
    // key in cell 0 is no larger than the key in cell 1
    `BMH_ASSERT(a_min_order, i_clk, i_rst_n, (w_link[0].valid && w_link[1].valid) |-> ($signed(w_link[0].key) <= $signed(w_link[1].key)), "chain out of order at the root")
    // a successful insert grows the queue by one
    `BMH_ASSERT(a_insert_grows, i_clk, i_rst_n, w_ctl.ins |=> (r_count == $past(r_count) + CW'(1)), "insert did not grow the count")
    // reset returns the sequencer to idle
    `BMH_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "sequencer not idle after reset")

endmodule

// ----- hdl/bmh_cell.sv -----
// one slot of the sorted key chain
// depends on bmh_pkg
module bmh_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmh_pkg::t_cell_ctl i_ctl,
    input  bmh_pkg::t_link    i_prev,
    input  bmh_pkg::t_link    i_next,
    output bmh_pkg::t_link    o_link
);
    import bmh_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             r_valid;
    logic             n_valid;
    logic             r_seen;
    logic             n_seen;
    logic             w_gt;
    logic             w_ge;
    logic             w_eq;

    assign w_gt = !r_valid || ($signed(r_key) > $signed(i_ctl.key));
    assign w_ge = r_valid && ($signed(r_key) >= $signed(i_ctl.key));
    assign w_eq = r_valid && (r_key == i_ctl.key);

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        n_seen  = r_seen;
        if (i_ctl.ins && w_gt) begin
            // first larger slot takes the new key, the rest shift up by one
            if (i_prev.gt) begin
                n_key   = i_prev.key;
                n_valid = i_prev.valid;
            end else begin
                n_key   = i_ctl.key;
                n_valid = 1'b1;
            end
        end else if (i_ctl.rem && w_ge) begin
            // matching slot and all above it close the gap
            n_key   = i_next.key;
            n_valid = i_next.valid;
        end
        if (i_ctl.scan) begin
            n_seen = i_prev.seen | w_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key  <= n_key;
        r_seen <= n_seen;
    end

    assign o_link.key   = r_key;
    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.seen  = r_seen;

endmodule
